@@ hw/rtl/rgb_to_gray_sobel_edge_assert.svh @@
// ----------------------------------------------------------------------------
// rgb_to_gray_sobel_edge_assert.svh
// Assertion macros for the gray/Sobel edge block.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_GRAY_SOBEL_EDGE_ASSERT_SVH
`define RGB_TO_GRAY_SOBEL_EDGE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RGSE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define RGSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/rgse_pkg.sv @@
// ----------------------------------------------------------------------------
// rgse_pkg
// Shared constants and types of the gray/Sobel edge block.
// ----------------------------------------------------------------------------
`default_nettype none

package rgse_pkg;

	localparam int unsigned CFG_W          = 12;
	localparam int unsigned CHAN_W         = 8;
	localparam int unsigned GRAY_W         = 8;
	localparam int unsigned COORD_W        = 11;
	localparam int unsigned MAX_WIDTH_DEF  = 2048;
	localparam int unsigned MAX_HEIGHT_DEF = 2048;
	localparam int unsigned MIN_WIDTH      = 3;

	localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 12'd640;

	// luma weights in 1/256 units
	localparam logic [7:0] W_A = 8'd77;
	localparam logic [7:0] W_B = 8'd150;
	localparam logic [7:0] W_C = 8'd29;

	localparam logic [GRAY_W-1:0] EDGE_MAX = 8'd255;

	typedef logic [GRAY_W-1:0] gray_t;
	typedef logic [CHAN_W-1:0] chan_t;

	// one column of the two stored rows
	typedef struct packed {
		gray_t top;
		gray_t mid;
	} col_pair_t;

	// 3x3 window, row-major, top row first, oldest column at the low index
	typedef gray_t [8:0] win_t;

endpackage

`default_nettype wire

@@ hw/rtl/rgse_pixel_if.sv @@
// ----------------------------------------------------------------------------
// rgse_pixel_if
// Input channel: one color pixel item with frame start mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgse_pixel_if;
	import rgse_pkg::*;

	logic  valid;
	logic  ready;
	logic  frame_start;
	chan_t chan_a;
	chan_t chan_b;
	chan_t chan_c;

	modport source (output valid, output frame_start, output chan_a, output chan_b,
		output chan_c, input ready);
	modport sink (input valid, input frame_start, input chan_a, input chan_b,
		input chan_c, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rgse_result_if.sv @@
// ----------------------------------------------------------------------------
// rgse_result_if
// Output channel: one edge item with center coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgse_result_if;
	import rgse_pkg::*;

	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] center_row;
	logic [COORD_W-1:0] center_col;
	gray_t              edge_value;

	modport source (output valid, output center_row, output center_col,
		output edge_value, input ready);
	modport sink (input valid, input center_row, input center_col,
		input edge_value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rgb_to_gray_sobel_edge.sv @@
// ----------------------------------------------------------------------------
// rgb_to_gray_sobel_edge
// Streaming gray conversion and 3x3 Sobel edge magnitude on raster pixels.
//
//   channel  dir  handshake     payload
//   pixel    in   valid/ready   frame_start, chan_a, chan_b, chan_c
//   result   out  valid/ready   center_row, center_col, edge_value
//   cfg      in   cfg_we        cfg_wdata -> line_width
//
// One item per cycle sustained while results are taken. An accepted pixel is
// registered in stage 1 (reads the line store), then stage 2 (holds the
// window); Sobel then feeds its result into the output register.
// Only pixels at row >= 2 and column >= 2 produce a result; others none.
// Reset clears counters, valid flags, window and width, not the line store.
// A stalled result holds every full stage in the same cycle; bubbles close up.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_gray_sobel_edge #(
	parameter int unsigned MAX_WIDTH  = rgse_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = rgse_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [rgse_pkg::CFG_W-1:0] cfg_wdata,
	rgse_pixel_if.sink                      pixel,
	rgse_result_if.source                   result
);
	import rgse_pkg::*;

	localparam int unsigned CW  = $clog2(MAX_WIDTH);
	localparam int unsigned RW  = $clog2(MAX_HEIGHT);
	localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
	localparam int unsigned EW  = (WW > CFG_W) ? WW : CFG_W;
	localparam int unsigned CXW = (CW > COORD_W) ? CW : COORD_W;
	localparam int unsigned RXW = (RW > COORD_W) ? RW : COORD_W;

	// configuration and position
	logic [CFG_W-1:0] line_width_q;
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [EW-1:0]    wid_raw, wid_eff, col_ext;
	logic [CW-1:0]    col_cur;
	logic [RW-1:0]    row_cur;
	logic             row_end, emit_in, accept;

	// pipeline
	logic      v1_q, v2_q, ov_q;
	logic      adv1, adv2, free1, free2, out_free;
	chan_t     chan_a_s1, chan_b_s1, chan_c_s1;
	logic [CW-1:0] col_s1, col_s2;
	logic [RW-1:0] row_s1, row_s2;
	logic      emit_s1, emit_s2;
	gray_t     gray_s1;
	col_pair_t rd_pair, wr_pair;
	win_t      win_s2;
	gray_t     mag_s2;
	logic [CXW-1:0] ccol_s2;
	logic [RXW-1:0] crow_s2;
	logic [COORD_W-1:0] crow_q, ccol_q;
	gray_t     edge_q;

	always_comb begin
		wid_raw = EW'(line_width_q);
		if (wid_raw < EW'(MIN_WIDTH)) begin
			wid_eff = EW'(MIN_WIDTH);
		end else if (wid_raw > EW'(MAX_WIDTH)) begin
			wid_eff = EW'(MAX_WIDTH);
		end else begin
			wid_eff = wid_raw;
		end
		col_cur = pixel.frame_start ? '0 : col_q;
		row_cur = pixel.frame_start ? '0 : row_q;
		col_ext = EW'(col_cur);
		row_end = (col_ext + EW'(1)) >= wid_eff;
		emit_in = (row_cur >= RW'(2)) && (col_ext >= EW'(2)) && (col_ext < wid_eff);
	end

	// handshake chain
	assign out_free    = !ov_q || result.ready;
	assign adv2        = v2_q && out_free;
	assign free2       = !v2_q || adv2;
	assign adv1        = v1_q && free2;
	assign free1       = !v1_q || adv1;
	assign pixel.ready = free1;
	assign accept      = pixel.valid && free1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RST;
		end else if (cfg_we) begin
			line_width_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= (row_cur == RW'(MAX_HEIGHT - 1)) ? '0 : row_cur + RW'(1);
			end else begin
				col_q <= col_cur + CW'(1);
				row_q <= row_cur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (free1) begin
				v1_q <= pixel.valid;
			end
			if (free2) begin
				v2_q <= adv1;
			end
			if (adv2) begin
				ov_q <= emit_s2;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// stage 1: input register, line store read in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			chan_a_s1 <= pixel.chan_a;
			chan_b_s1 <= pixel.chan_b;
			chan_c_s1 <= pixel.chan_c;
			col_s1    <= col_cur;
			row_s1    <= row_cur;
			emit_s1   <= emit_in;
		end
	end

	rgse_gray u_gray (
		.chan_a (chan_a_s1),
		.chan_b (chan_b_s1),
		.chan_c (chan_c_s1),
		.gray   (gray_s1)
	);

	// rows shift down by one: old mid becomes top, new gray becomes mid
	assign wr_pair.top = rd_pair.mid;
	assign wr_pair.mid = gray_s1;

	rgse_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (col_cur),
		.wr_en   (adv1),
		.wr_addr (col_s1),
		.wr_data (wr_pair),
		.rd_data (rd_pair)
	);

	// stage 2: 3x3 window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_s2 <= '0;
		end else if (adv1) begin
			win_s2[0] <= win_s2[1];
			win_s2[1] <= win_s2[2];
			win_s2[2] <= rd_pair.top;
			win_s2[3] <= win_s2[4];
			win_s2[4] <= win_s2[5];
			win_s2[5] <= rd_pair.mid;
			win_s2[6] <= win_s2[7];
			win_s2[7] <= win_s2[8];
			win_s2[8] <= gray_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			col_s2  <= col_s1;
			row_s2  <= row_s1;
			emit_s2 <= emit_s1;
		end
	end

	rgse_sobel u_sobel (
		.win (win_s2),
		.mag (mag_s2)
	);

	assign ccol_s2 = CXW'(col_s2) - CXW'(1);
	assign crow_s2 = RXW'(row_s2) - RXW'(1);

	// output register
	always_ff @(posedge clk) begin
		if (adv2) begin
			crow_q <= crow_s2[COORD_W-1:0];
			ccol_q <= ccol_s2[COORD_W-1:0];
			edge_q <= mag_s2;
		end
	end

	assign result.valid      = ov_q;
	assign result.center_row = crow_q;
	assign result.center_col = ccol_q;
	assign result.edge_value = edge_q;

`include "rgb_to_gray_sobel_edge_assert.svh"

	`RGSE_ASSERT_NEXT(a_s1_hold, clk, arst_n, v1_q && !adv1, v1_q && $stable(col_s1), "stage 1 lost")
	`RGSE_ASSERT_NEXT(a_s2_hold, clk, arst_n, v2_q && !out_free, v2_q, "stage 2 item dropped")
	`RGSE_ASSERT_NEXT(a_no_spurious, clk, arst_n, !ov_q && !(v2_q && emit_s2), !ov_q, "stray result")

endmodule

`default_nettype wire

@@ hw/rtl/rgse_gray.sv @@
// ----------------------------------------------------------------------------
// rgse_gray
// Fixed-point gray conversion: (77*a + 150*b + 29*c) >> 8.
// ----------------------------------------------------------------------------
`default_nettype none

module rgse_gray (
	input  wire rgse_pkg::chan_t chan_a,
	input  wire rgse_pkg::chan_t chan_b,
	input  wire rgse_pkg::chan_t chan_c,
	output rgse_pkg::gray_t      gray
);
	import rgse_pkg::*;

	logic [15:0] sum;

	always_comb begin
		sum = ({8'd0, chan_a} * {8'd0, W_A})
			+ ({8'd0, chan_b} * {8'd0, W_B})
			+ ({8'd0, chan_c} * {8'd0, W_C});
	end

	assign gray = sum[15:8];
endmodule

`default_nettype wire

@@ hw/rtl/rgse_line_store.sv @@
// ----------------------------------------------------------------------------
// rgse_line_store
// Two-row gray line store, one column pair per word, registered read with
// bypass of a write to the same column in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rgse_line_store #(
	parameter int unsigned DEPTH = rgse_pkg::MAX_WIDTH_DEF,
	parameter int unsigned AW    = $clog2(rgse_pkg::MAX_WIDTH_DEF)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                rd_en,
	input  wire logic [AW-1:0]       rd_addr,
	input  wire logic                wr_en,
	input  wire logic [AW-1:0]       wr_addr,
	input  wire rgse_pkg::col_pair_t wr_data,
	output rgse_pkg::col_pair_t      rd_data
);
	import rgse_pkg::*;

	col_pair_t mem [DEPTH];
	col_pair_t rd_q;
	col_pair_t byp_q;
	logic      byp_sel_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q  <= mem[rd_addr];
			byp_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_sel_q <= 1'b0;
		end else if (rd_en) begin
			byp_sel_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_sel_q ? byp_q : rd_q;
endmodule

`default_nettype wire

@@ hw/rtl/rgse_sobel.sv @@
// ----------------------------------------------------------------------------
// rgse_sobel
// 3x3 Sobel gradients on a gray window, |gx| + |gy| saturated to 8 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rgse_sobel (
	input  wire rgse_pkg::win_t win,
	output rgse_pkg::gray_t     mag
);
	import rgse_pkg::*;

	logic [9:0]         gx_p, gx_n, gy_p, gy_n;
	logic signed [10:0] gx, gy;
	logic [9:0]         ax, ay;
	logic [10:0]        sum;

	always_comb begin
		gx_p = {2'd0, win[2]} + {1'b0, win[5], 1'b0} + {2'd0, win[8]};
		gx_n = {2'd0, win[0]} + {1'b0, win[3], 1'b0} + {2'd0, win[6]};
		gy_p = {2'd0, win[6]} + {1'b0, win[7], 1'b0} + {2'd0, win[8]};
		gy_n = {2'd0, win[0]} + {1'b0, win[1], 1'b0} + {2'd0, win[2]};
		gx   = $signed({1'b0, gx_p}) - $signed({1'b0, gx_n});
		gy   = $signed({1'b0, gy_p}) - $signed({1'b0, gy_n});
		ax   = gx[10] ? 10'(-gx) : gx[9:0];
		ay   = gy[10] ? 10'(-gy) : gy[9:0];
		sum  = {1'b0, ax} + {1'b0, ay};
		mag  = (sum > {3'd0, EDGE_MAX}) ? EDGE_MAX : sum[7:0];
	end
endmodule

`default_nettype wire

@@ tb/tb_rgb_to_gray_sobel_edge.sv @@
// ----------------------------------------------------------------------------
// tb_rgb_to_gray_sobel_edge
// Self-checking bench for the gray conversion and Sobel edge block.
//
// Color pixel items go in raster order, with random gaps on the pixel side
// and random stalls on the result side. A scoreboard keeps its own line
// store, window and position counters, works out the edge item each pixel
// should cause, and compares every result item field by field. The row
// width is changed only while the block is drained. The run covers the
// reset width, clamped low widths, frame restarts and width cuts.
// ----------------------------------------------------------------------------
module tb_rgb_to_gray_sobel_edge;
	import rgse_pkg::*;

	localparam int unsigned MAXW           = MAX_WIDTH_DEF;
	localparam int unsigned MAXH           = MAX_HEIGHT_DEF;
	localparam int unsigned DRAIN_CYCLES   = 10;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned RANDOM_ITEMS   = 560;

	localparam logic [23:0] PX_WHITE = 24'hFFFFFF;
	localparam logic [23:0] PX_BLACK = 24'h000000;
	localparam logic [23:0] PX_RED   = 24'hFF0000;
	localparam logic [23:0] PX_GREEN = 24'h00FF00;
	localparam logic [23:0] PX_BLUE  = 24'h0000FF;
	localparam logic [23:0] PX_MID   = 24'h808080;

	typedef enum int unsigned {
		CONTENT_NOISE,
		CONTENT_EXTREME,
		CONTENT_SMOOTH
	} content_e;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		gray_t              mag;
	} edge_item_t;

	class edge_scoreboard;
		gray_t            prev_row [MAXW];
		gray_t            prev2_row [MAXW];
		gray_t            win [9];
		int unsigned      col_pos;
		int unsigned      row_pos;
		logic [CFG_W-1:0] line_width;
		edge_item_t       expected_edges [$];
		int unsigned      errors;

		function new();
			foreach (prev_row[i]) begin
				prev_row[i]  = '0;
				prev2_row[i] = '0;
			end
			foreach (win[i])
				win[i] = '0;
			col_pos    = 0;
			row_pos    = 0;
			line_width = LINE_WIDTH_RST;
			errors     = 0;
		endfunction

		function int unsigned used_width();
			int unsigned w;
			w = 32'(line_width);
			if (w < MIN_WIDTH)
				w = MIN_WIDTH;
			if (w > MAXW)
				w = MAXW;
			return w;
		endfunction

		function void note_pixel(logic fs, chan_t a, chan_t b, chan_t c);
			int unsigned w, cc, rr;
			int          k, gx, gy, mag;
			gray_t       g, top, mid;
			edge_item_t  e;
			w = used_width();
			if (fs) begin
				col_pos = 0;
				row_pos = 0;
			end
			cc = col_pos;
			rr = row_pos;
			g = gray_t'((int'(W_A) * int'(a) + int'(W_B) * int'(b) + int'(W_C) * int'(c)) >> 8);
			top = prev2_row[cc];
			mid = prev_row[cc];
			prev2_row[cc] = mid;
			prev_row[cc]  = g;
			for (k = 0; k < 3; k++) begin
				win[3*k]   = win[3*k+1];
				win[3*k+1] = win[3*k+2];
			end
			win[2] = top;
			win[5] = mid;
			win[8] = g;
			if (rr >= 2 && cc >= 2 && cc <= w - 1) begin
				gx = (int'(win[2]) + 2 * int'(win[5]) + int'(win[8]))
					- (int'(win[0]) + 2 * int'(win[3]) + int'(win[6]));
				gy = (int'(win[6]) + 2 * int'(win[7]) + int'(win[8]))
					- (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
				if (gx < 0)
					gx = -gx;
				if (gy < 0)
					gy = -gy;
				mag = gx + gy;
				if (mag > int'(EDGE_MAX))
					mag = int'(EDGE_MAX);
				e.row = COORD_W'(rr - 1);
				e.col = COORD_W'(cc - 1);
				e.mag = gray_t'(mag);
				expected_edges.push_back(e);
			end
			if (cc + 1 >= w) begin
				col_pos = 0;
				row_pos = (rr + 1 >= MAXH) ? 0 : rr + 1;
			end else begin
				col_pos = cc + 1;
				row_pos = rr;
			end
		endfunction

		function void check_result(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
				gray_t mag);
			edge_item_t e;
			if (expected_edges.size() == 0) begin
				$error("unexpected edge item: row %0d col %0d value %0d", row, col, mag);
				errors++;
				return;
			end
			e = expected_edges.pop_front();
			if (row !== e.row) begin
				$error("center_row: expected %0d, actual %0d", e.row, row);
				errors++;
			end
			if (col !== e.col) begin
				$error("center_col: expected %0d, actual %0d", e.col, col);
				errors++;
			end
			if (mag !== e.mag) begin
				$error("edge_value: expected %0d, actual %0d", e.mag, mag);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_W-1:0]  cfg_wdata;

	rgse_pixel_if  pix_if ();
	rgse_result_if res_if ();

	rgb_to_gray_sobel_edge DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pixel     (pix_if),
		.result    (res_if)
	);

	edge_scoreboard sb = new();

	int unsigned src_idle_pct;
	int unsigned sink_idle_pct;
	int unsigned quiet_cycles;
	int unsigned random_items;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned pick_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic int unsigned pick_gap();
		if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
			return pick_len();
		return 0;
	endfunction

	function automatic void set_idle_mode();
		case ($urandom_range(0, 3))
			0: begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			1: begin
				src_idle_pct  = 10;
				sink_idle_pct = 10;
			end
			2: begin
				src_idle_pct  = 40;
				sink_idle_pct = 40;
			end
			default: begin
				src_idle_pct  = $urandom_range(0, 60);
				sink_idle_pct = $urandom_range(0, 60);
			end
		endcase
	endfunction

	function automatic chan_t make_chan(content_e style, chan_t base);
		case (style)
			CONTENT_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			CONTENT_SMOOTH:  return base + chan_t'($urandom_range(0, 7));
			default:         return chan_t'($urandom_range(0, 255));
		endcase
	endfunction

	// result side: random stalls, held for a picked length
	initial begin
		int unsigned stall_left;
		stall_left   = 0;
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				res_if.ready <= 1'b0;
			end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
				stall_left = pick_len() - 1;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles = 0;
		end else begin
			if (res_if.valid && res_if.ready)
				sb.check_result(res_if.center_row, res_if.center_col, res_if.edge_value);
			if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("** rgb_to_gray_sobel_edge: FAILED **");
		$finish;
	end

	task automatic send_pixel(logic fs, chan_t a, chan_t b, chan_t c);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			pix_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_if.valid       <= 1'b1;
		pix_if.frame_start <= fs;
		pix_if.chan_a      <= a;
		pix_if.chan_b      <= b;
		pix_if.chan_c      <= c;
		do
			@(posedge clk);
		while (!pix_if.ready);
		sb.note_pixel(fs, a, b, c);
	endtask

	task automatic wait_drained();
		pix_if.valid <= 1'b0;
		while (sb.expected_edges.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_width(logic [CFG_W-1:0] value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.line_width = value;
	endtask

	// n_pix items, the first one marked as frame start when first_fs is set
	task automatic send_frame(int unsigned n_pix, content_e style, logic first_fs,
			int unsigned noise_pm);
		chan_t ba, bb, bc;
		logic  fs;
		ba = chan_t'($urandom_range(0, 248));
		bb = chan_t'($urandom_range(0, 248));
		bc = chan_t'($urandom_range(0, 248));
		for (int unsigned i = 0; i < n_pix; i++) begin
			fs = (first_fs && i == 0) || (noise_pm != 0 && $urandom_range(0, 999) < noise_pm);
			send_pixel(fs, make_chan(style, ba), make_chan(style, bb), make_chan(style, bc));
		end
	endtask

	initial begin
		logic [24:0]     directed [24];
		logic [CFG_W-1:0] wcfg;
		int unsigned      cols, rows, n_pix, n_first, n_rest, budget;
		content_e         style;

		directed = '{
			{1'b1, PX_WHITE}, {1'b0, PX_BLACK}, {1'b0, PX_BLACK},
			{1'b0, PX_WHITE}, {1'b0, PX_BLACK}, {1'b0, PX_BLACK},
			{1'b0, PX_WHITE}, {1'b0, PX_BLACK}, {1'b0, PX_BLACK},
			{1'b0, PX_BLACK}, {1'b0, PX_BLACK}, {1'b0, PX_BLACK},
			{1'b0, PX_RED},   {1'b0, PX_GREEN}, {1'b0, PX_BLUE},
			{1'b0, PX_MID},   {1'b0, PX_MID},   {1'b0, PX_MID},
			{1'b0, PX_MID},   {1'b0, PX_MID},   {1'b0, PX_MID},
			{1'b0, PX_MID},   {1'b1, PX_WHITE}, {1'b0, PX_BLACK}
		};

		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		pix_if.valid       = 1'b0;
		pix_if.frame_start = 1'b0;
		pix_if.chan_a      = '0;
		pix_if.chan_b      = '0;
		pix_if.chan_c      = '0;
		src_idle_pct       = 10;
		sink_idle_pct      = 10;
		random_items       = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset width: two full rows and the start of the third
		send_frame(2 * 640 + 8, CONTENT_SMOOTH, 1'b1, 0);

		write_width(12'd3);
		set_idle_mode();
		foreach (directed[i])
			send_pixel(directed[i][24], directed[i][23:16], directed[i][15:8],
				directed[i][7:0]);

		// clamped low widths
		write_width(12'd0);
		send_frame(3 * 5, CONTENT_NOISE, 1'b1, 0);
		write_width(12'd2);
		send_frame(3 * 4, CONTENT_SMOOTH, 1'b1, 0);

		while (random_items < RANDOM_ITEMS) begin
			set_idle_mode();
			case ($urandom_range(0, 99)) inside
				[0:69]:  wcfg = CFG_W'($urandom_range(3, 10));
				[70:84]: wcfg = CFG_W'($urandom_range(11, 40));
				[85:91]: wcfg = CFG_W'($urandom_range(0, 2));
				default: wcfg = CFG_W'($urandom_range(41, 200));
			endcase
			write_width(wcfg);
			budget = RANDOM_ITEMS - random_items;
			cols   = sb.used_width();
			rows   = (cols > 40) ? $urandom_range(3, 4) : $urandom_range(1, 8);
			n_pix  = cols * rows;
			if (n_pix > budget)
				n_pix = budget;
			style = content_e'($urandom_range(0, 2));
			case ($urandom_range(0, 9))
				0: begin
					n_pix = $urandom_range(1, n_pix);
					send_frame(n_pix, style, 1'b1, 0);
				end
				1: begin
					// cut the width in the middle of a frame
					n_first = $urandom_range(1, n_pix);
					send_frame(n_first, style, 1'b1, 0);
					write_width(CFG_W'($urandom_range(0, cols)));
					cols   = sb.used_width();
					n_rest = cols * $urandom_range(1, 5);
					if (n_rest > budget - n_first)
						n_rest = budget - n_first;
					send_frame(n_rest, style, 1'b0, 0);
					n_pix = n_first + n_rest;
				end
				default: send_frame(n_pix, style, 1'b1, 5);
			endcase
			random_items += n_pix;
		end

		wait_drained();
		if (sb.errors == 0 && sb.expected_edges.size() == 0)
			$display("** rgb_to_gray_sobel_edge: PASSED **");
		else
			$display("** rgb_to_gray_sobel_edge: FAILED **");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/rgse_pkg.sv
hw/rtl/rgse_pixel_if.sv
hw/rtl/rgse_result_if.sv
hw/rtl/rgse_gray.sv
hw/rtl/rgse_line_store.sv
hw/rtl/rgse_sobel.sv
hw/rtl/rgb_to_gray_sobel_edge.sv
tb/tb_rgb_to_gray_sobel_edge.sv
